// File: sv/assert_macros.svh
// Assertion macros used by the vector arithmetic unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge, except while reset is asserted.
`define V3A_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checks that expr holds in the cycle after cond, except while reset is asserted.
`define V3A_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// File: sv/v3a_pkg.sv
// Types, constants and step functions of the vector arithmetic unit.
`default_nettype none

package v3a_pkg;

    localparam logic [3:0] FN_ADD   = 4'd0;
    localparam logic [3:0] FN_ADDS  = 4'd1;
    localparam logic [3:0] FN_SUB   = 4'd2;
    localparam logic [3:0] FN_SUBS  = 4'd3;
    localparam logic [3:0] FN_MUL   = 4'd4;
    localparam logic [3:0] FN_MULS  = 4'd5;
    localparam logic [3:0] FN_DIV   = 4'd6;
    localparam logic [3:0] FN_DIVS  = 4'd7;
    localparam logic [3:0] FN_DOT   = 4'd8;
    localparam logic [3:0] FN_CROSS = 4'd9;
    localparam logic [3:0] FN_MAG   = 4'd10;
    localparam logic [3:0] FN_NORM  = 4'd11;
    localparam logic [3:0] FN_EQ    = 4'd12;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    localparam int SQ_PER_STAGE  = 2;
    localparam int SQ_STAGES     = 32 / SQ_PER_STAGE;
    localparam int DIV_PER_STAGE = 2;
    localparam int DIV_STAGES    = 48 / DIV_PER_STAGE;

    typedef logic [2:0][31:0] t_vec;
    typedef logic [2:0][47:0] t_quo;

    typedef struct packed {
        logic [3:0] func;
        t_vec       a;
        t_vec       d;
        t_vec       r;
        logic       eq;
        logic       flt;
    } t_side;

    typedef struct packed {
        logic [3:0]  func;
        t_vec        r;
        logic [31:0] root;
        logic        eq;
        logic        flt;
        logic [2:0]  neg;
        logic [2:0]  dz;
    } t_dside;

    typedef struct packed {
        t_vec r;
        logic eq;
        logic flt;
    } t_res;

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] root;
    } t_sq;

    typedef struct packed {
        logic [31:0] rem;
        logic [47:0] nq;
    } t_dv;

    typedef struct packed {
        logic [31:0] q;
        logic        ovf;
    } t_sat;

    function automatic t_sq sqrt_step(input logic [32:0] rem, input logic [31:0] root,
                                      input logic [1:0] bits);
        logic [34:0] cur;
        logic [34:0] trial;
        t_sq         res;
        cur   = {rem, bits};
        trial = {1'b0, root, 2'b01};
        if (cur >= trial) begin
            res.rem  = 33'(cur - trial);
            res.root = {root[30:0], 1'b1};
        end else begin
            res.rem  = cur[32:0];
            res.root = {root[30:0], 1'b0};
        end
        return res;
    endfunction

    function automatic t_dv div_step(input logic [31:0] rem, input logic [47:0] nq,
                                     input logic [31:0] den);
        logic [32:0] cur;
        logic [32:0] diff;
        t_dv         res;
        cur  = {rem, nq[47]};
        diff = cur - {1'b0, den};
        if (cur >= {1'b0, den}) begin
            res.rem = diff[31:0];
            res.nq  = {nq[46:0], 1'b1};
        end else begin
            res.rem = cur[31:0];
            res.nq  = {nq[46:0], 1'b0};
        end
        return res;
    endfunction

    function automatic t_sat sat66(input logic signed [65:0] v);
        t_sat res;
        res.ovf = 1'b0;
        res.q   = v[31:0];
        if (v > 66'(Q_MAX)) begin
            res.q   = Q_MAX;
            res.ovf = 1'b1;
        end else if (v < 66'(Q_MIN)) begin
            res.q   = Q_MIN;
            res.ovf = 1'b1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: sv/vec3_arith_unit_core.sv
// Top level of the pipelined three-component Q16.16 vector arithmetic unit.
//
//  channel  | valid       | ready       | payload
//  ---------+-------------+-------------+--------------------------------------
//  input    | i_in_valid  | o_in_ready  | i_func, i_ax..i_az, i_bx..i_bz, i_s
//  output   | o_out_valid | i_out_ready | o_rx, o_ry, o_rz, o_is_equal, o_fault
//
// One item is accepted per cycle, except while a full skid register stalls the pipeline.
// Items pass through the front stages, the 16-stage square root and the 24-stage divider.
// Reset is synchronous and active low and empties every stage at once.
// A held output parks one item in a skid register, after which the whole pipeline stalls.
`default_nettype none
`include "assert_macros.svh"

module vec3_arith_unit_core
    import v3a_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_func,
    input  wire logic [31:0] i_ax,
    input  wire logic [31:0] i_ay,
    input  wire logic [31:0] i_az,
    input  wire logic [31:0] i_bx,
    input  wire logic [31:0] i_by,
    input  wire logic [31:0] i_bz,
    input  wire logic [31:0] i_s,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_rx,
    output logic [31:0]      o_ry,
    output logic [31:0]      o_rz,
    output logic             o_is_equal,
    output logic             o_fault
);

    logic        en;
    t_vec        in_a;
    t_vec        in_b;

    logic        fr_vld;
    t_side       fr_side;
    logic [63:0] fr_sumsq;

    logic        sq_vld;
    logic [31:0] sq_root;
    t_side       sq_side;

    logic        dv_vld;
    t_quo        dv_q;
    t_dside      dv_side;

    t_res        n_fin;
    logic        r_fin_vld;
    t_res        r_fin;

    logic        out_free;
    logic        r_out_vld;
    t_res        r_out;
    logic        n_out_vld;
    t_res        n_out;
    logic        r_skid_vld;
    t_res        r_skid;
    logic        n_skid_vld;
    t_res        n_skid;

    assign en         = !r_skid_vld;
    assign o_in_ready = en;
    assign in_a       = {i_az, i_ay, i_ax};
    assign in_b       = {i_bz, i_by, i_bx};

    v3a_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_func  (i_func),
        .i_a     (in_a),
        .i_b     (in_b),
        .i_s     (i_s),
        .o_valid (fr_vld),
        .o_side  (fr_side),
        .o_sumsq (fr_sumsq)
    );

    v3a_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_vld),
        .i_sumsq (fr_sumsq),
        .i_side  (fr_side),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    v3a_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_vld),
        .i_root  (sq_root),
        .i_side  (sq_side),
        .o_valid (dv_vld),
        .o_q     (dv_q),
        .o_side  (dv_side)
    );

    always_comb begin
        n_fin.r   = dv_side.r;
        n_fin.eq  = dv_side.eq;
        n_fin.flt = dv_side.flt;
        case (dv_side.func)
            FN_DIV, FN_DIVS, FN_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    if (dv_side.dz[i]) begin
                        n_fin.r[i] = '0;
                        n_fin.flt  = 1'b1;
                    end else if (dv_side.neg[i]) begin
                        if (dv_q[i] > 48'h0000_8000_0000) begin
                            n_fin.r[i] = Q_MIN;
                            n_fin.flt  = 1'b1;
                        end else begin
                            n_fin.r[i] = 32'h0 - dv_q[i][31:0];
                        end
                    end else if (dv_q[i] > 48'h0000_7FFF_FFFF) begin
                        n_fin.r[i] = Q_MAX;
                        n_fin.flt  = 1'b1;
                    end else begin
                        n_fin.r[i] = dv_q[i][31:0];
                    end
                end
            end
            FN_MAG: begin
                if (dv_side.root[31]) begin
                    n_fin.r[0] = Q_MAX;
                    n_fin.flt  = 1'b1;
                end else begin
                    n_fin.r[0] = dv_side.root;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else if (en) begin
            r_fin_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fin <= n_fin;
        end
    end

    assign out_free = !r_out_vld || i_out_ready;

    always_comb begin
        n_out      = r_out;
        n_out_vld  = r_out_vld;
        n_skid     = r_skid;
        n_skid_vld = r_skid_vld;
        if (out_free) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_out_vld  = 1'b1;
                n_skid_vld = 1'b0;
            end else begin
                n_out     = r_fin;
                n_out_vld = r_fin_vld;
            end
        end else if (!r_skid_vld && r_fin_vld) begin
            n_skid     = r_fin;
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_vld;
    assign o_rx        = r_out.r[0];
    assign o_ry        = r_out.r[1];
    assign o_rz        = r_out.r[2];
    assign o_is_equal  = r_out.eq;
    assign o_fault     = r_out.flt;

    `V3A_ASSERT(a_skid_needs_out, r_skid_vld |-> r_out_vld, "skid item without output item")
    `V3A_ASSERT(a_skid_fill, $rose(r_skid_vld) |-> $past(r_out_vld && !i_out_ready), "skid filled while output was free")
    `V3A_ASSERT_NEXT(a_skid_drain, r_skid_vld && i_out_ready, !r_skid_vld && r_out_vld, "skid item not moved to output")
    `V3A_ASSERT(a_equal_clean, o_out_valid && o_is_equal |-> !o_fault && o_rx == '0, "equal result with fault or data")

endmodule

`default_nettype wire

// File: sv/v3a_front.sv
// Input register, multipliers, sums and saturation of the simple operations.
`default_nettype none

module v3a_front
    import v3a_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [3:0]  i_func,
    input  wire t_vec        i_a,
    input  wire t_vec        i_b,
    input  wire logic [31:0] i_s,
    output logic             o_valid,
    output t_side            o_side,
    output logic [63:0]      o_sumsq
);

    logic        r_s0_vld;
    logic [3:0]  r_s0_func;
    t_vec        r_s0_a;
    t_vec        r_s0_b;
    logic [31:0] r_s0_s;

    logic signed [31:0] n_ma [6];
    logic signed [31:0] n_mb [6];
    logic signed [63:0] n_prod [6];

    logic               r_s1_vld;
    logic [3:0]         r_s1_func;
    t_vec               r_s1_a;
    t_vec               r_s1_b;
    logic [31:0]        r_s1_s;
    logic signed [63:0] r_s1_prod [6];

    logic signed [65:0] n_sum3;
    logic signed [65:0] n_v [3];
    logic [31:0]        n_opnd [3];
    t_vec               n_d;
    logic               n_eq;

    logic               r_s2_vld;
    logic [3:0]         r_s2_func;
    t_vec               r_s2_a;
    t_vec               r_s2_d;
    logic signed [65:0] r_s2_v [3];
    logic               r_s2_eq;
    logic [63:0]        r_s2_sumsq;

    t_side n_side;
    t_sat  n_sat [3];

    logic        r_s3_vld;
    t_side       r_s3_side;
    logic [63:0] r_s3_sumsq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (i_en) begin
            r_s0_vld <= i_valid;
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0_func <= i_func;
            r_s0_a    <= i_a;
            r_s0_b    <= i_b;
            r_s0_s    <= i_s;
        end
    end

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n_ma[k] = '0;
            n_mb[k] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            n_ma[i] = r_s0_a[i];
            n_mb[i] = r_s0_b[i];
        end
        case (r_s0_func)
            FN_MULS: begin
                for (int i = 0; i < 3; i++) n_mb[i] = r_s0_s;
            end
            FN_MAG, FN_NORM: begin
                for (int i = 0; i < 3; i++) n_mb[i] = r_s0_a[i];
            end
            FN_CROSS: begin
                n_ma[0] = r_s0_a[1];  n_mb[0] = r_s0_b[2];
                n_ma[1] = r_s0_a[2];  n_mb[1] = r_s0_b[1];
                n_ma[2] = r_s0_a[2];  n_mb[2] = r_s0_b[0];
                n_ma[3] = r_s0_a[0];  n_mb[3] = r_s0_b[2];
                n_ma[4] = r_s0_a[0];  n_mb[4] = r_s0_b[1];
                n_ma[5] = r_s0_a[1];  n_mb[5] = r_s0_b[0];
            end
            default: begin
            end
        endcase
        for (int k = 0; k < 6; k++) begin
            n_prod[k] = 64'(n_ma[k]) * 64'(n_mb[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_func <= r_s0_func;
            r_s1_a    <= r_s0_a;
            r_s1_b    <= r_s0_b;
            r_s1_s    <= r_s0_s;
            for (int k = 0; k < 6; k++) r_s1_prod[k] <= n_prod[k];
        end
    end

    always_comb begin
        n_sum3 = 66'(r_s1_prod[0]) + 66'(r_s1_prod[1]) + 66'(r_s1_prod[2]);
        for (int i = 0; i < 3; i++) begin
            n_v[i]    = '0;
            n_opnd[i] = ((r_s1_func == FN_ADDS) || (r_s1_func == FN_SUBS)) ? r_s1_s : r_s1_b[i];
            n_d[i]    = (r_s1_func == FN_DIVS) ? r_s1_s : r_s1_b[i];
        end
        case (r_s1_func)
            FN_ADD, FN_ADDS: begin
                for (int i = 0; i < 3; i++)
                    n_v[i] = 66'($signed(r_s1_a[i])) + 66'($signed(n_opnd[i]));
            end
            FN_SUB, FN_SUBS: begin
                for (int i = 0; i < 3; i++)
                    n_v[i] = 66'($signed(r_s1_a[i])) - 66'($signed(n_opnd[i]));
            end
            FN_MUL, FN_MULS: begin
                for (int i = 0; i < 3; i++) n_v[i] = 66'(r_s1_prod[i]) >>> 16;
            end
            FN_DOT: begin
                n_v[0] = n_sum3 >>> 16;
            end
            FN_CROSS: begin
                n_v[0] = (66'(r_s1_prod[0]) - 66'(r_s1_prod[1])) >>> 16;
                n_v[1] = (66'(r_s1_prod[2]) - 66'(r_s1_prod[3])) >>> 16;
                n_v[2] = (66'(r_s1_prod[4]) - 66'(r_s1_prod[5])) >>> 16;
            end
            default: begin
            end
        endcase
        n_eq = (r_s1_func == FN_EQ) && (r_s1_a == r_s1_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_func  <= r_s1_func;
            r_s2_a     <= r_s1_a;
            r_s2_d     <= n_d;
            for (int i = 0; i < 3; i++) r_s2_v[i] <= n_v[i];
            r_s2_eq    <= n_eq;
            r_s2_sumsq <= n_sum3[63:0];
        end
    end

    always_comb begin
        n_side.func = r_s2_func;
        n_side.a    = r_s2_a;
        n_side.d    = r_s2_d;
        n_side.eq   = r_s2_eq;
        n_side.flt  = (r_s2_func > FN_EQ);
        for (int i = 0; i < 3; i++) begin
            n_sat[i]    = sat66(r_s2_v[i]);
            n_side.r[i] = n_sat[i].q;
            n_side.flt  = n_side.flt | n_sat[i].ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_side  <= n_side;
            r_s3_sumsq <= r_s2_sumsq;
        end
    end

    assign o_valid = r_s3_vld;
    assign o_side  = r_s3_side;
    assign o_sumsq = r_s3_sumsq;

endmodule

`default_nettype wire

// File: sv/v3a_sqrt.sv
// Pipelined integer square root of the sum of squares, two result bits a stage.
`default_nettype none

module v3a_sqrt
    import v3a_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [63:0] i_sumsq,
    input  wire t_side       i_side,
    output logic             o_valid,
    output logic [31:0]      o_root,
    output t_side            o_side
);

    logic        r_vld  [SQ_STAGES];
    logic [63:0] r_n    [SQ_STAGES];
    logic [32:0] r_rem  [SQ_STAGES];
    logic [31:0] r_root [SQ_STAGES];
    t_side       r_side [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        logic        src_vld;
        logic [63:0] src_n;
        logic [32:0] src_rem;
        logic [31:0] src_root;
        t_side       src_side;
        logic [63:0] n_n;
        logic [32:0] n_rem;
        logic [31:0] n_root;
        t_sq         st;

        if (k == 0) begin : g_first
            assign src_vld  = i_valid;
            assign src_n    = i_sumsq;
            assign src_rem  = '0;
            assign src_root = '0;
            assign src_side = i_side;
        end else begin : g_next
            assign src_vld  = r_vld[k-1];
            assign src_n    = r_n[k-1];
            assign src_rem  = r_rem[k-1];
            assign src_root = r_root[k-1];
            assign src_side = r_side[k-1];
        end

        always_comb begin
            n_n    = src_n;
            n_rem  = src_rem;
            n_root = src_root;
            st     = '0;
            for (int j = 0; j < SQ_PER_STAGE; j++) begin
                st     = sqrt_step(n_rem, n_root, n_n[63:62]);
                n_rem  = st.rem;
                n_root = st.root;
                n_n    = {n_n[61:0], 2'b00};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k]    <= n_n;
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= src_side;
            end
        end
    end

    assign o_valid = r_vld[SQ_STAGES-1];
    assign o_root  = r_root[SQ_STAGES-1];
    assign o_side  = r_side[SQ_STAGES-1];

endmodule

`default_nettype wire

// File: sv/v3a_div.sv
// Operand preparation and three-lane pipelined restoring divider, two bits a stage.
`default_nettype none

module v3a_div
    import v3a_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_root,
    input  wire t_side       i_side,
    output logic             o_valid,
    output t_quo             o_q,
    output t_dside           o_side
);

    t_quo   n_p_nq;
    t_vec   n_p_den;
    t_dside n_p_side;
    logic   n_sa [3];
    logic   n_sd [3];

    logic   r_p_vld;
    t_quo   r_p_nq;
    t_vec   r_p_den;
    t_dside r_p_side;

    logic   r_vld  [DIV_STAGES];
    t_quo   r_nq   [DIV_STAGES];
    t_vec   r_rem  [DIV_STAGES];
    t_vec   r_den  [DIV_STAGES];
    t_dside r_ds   [DIV_STAGES];

    always_comb begin
        n_p_side.func = i_side.func;
        n_p_side.r    = i_side.r;
        n_p_side.root = i_root;
        n_p_side.eq   = i_side.eq;
        n_p_side.flt  = i_side.flt;
        for (int i = 0; i < 3; i++) begin
            n_sa[i]      = i_side.a[i][31];
            n_sd[i]      = i_side.d[i][31];
            n_p_nq[i]    = {(n_sa[i] ? 32'(-i_side.a[i]) : i_side.a[i]), 16'h0000};
            if (i_side.func == FN_NORM) begin
                n_p_den[i]     = i_root;
                n_p_side.neg[i] = n_sa[i];
                n_p_side.dz[i]  = (i_root == '0);
            end else begin
                n_p_den[i]      = n_sd[i] ? 32'(-i_side.d[i]) : i_side.d[i];
                n_p_side.neg[i] = n_sa[i] ^ n_sd[i];
                n_p_side.dz[i]  = (i_side.d[i] == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (i_en) begin
            r_p_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_nq   <= n_p_nq;
            r_p_den  <= n_p_den;
            r_p_side <= n_p_side;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic   src_vld;
        t_quo   src_nq;
        t_vec   src_rem;
        t_vec   src_den;
        t_dside src_ds;
        t_quo   n_nq;
        t_vec   n_rem;
        t_dv    st;

        if (k == 0) begin : g_first
            assign src_vld = r_p_vld;
            assign src_nq  = r_p_nq;
            assign src_rem = '0;
            assign src_den = r_p_den;
            assign src_ds  = r_p_side;
        end else begin : g_next
            assign src_vld = r_vld[k-1];
            assign src_nq  = r_nq[k-1];
            assign src_rem = r_rem[k-1];
            assign src_den = r_den[k-1];
            assign src_ds  = r_ds[k-1];
        end

        always_comb begin
            n_nq  = src_nq;
            n_rem = src_rem;
            st    = '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < DIV_PER_STAGE; j++) begin
                    st       = div_step(n_rem[i], n_nq[i], src_den[i]);
                    n_rem[i] = st.rem;
                    n_nq[i]  = st.nq;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nq[k]  <= n_nq;
                r_rem[k] <= n_rem;
                r_den[k] <= src_den;
                r_ds[k]  <= src_ds;
            end
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_q     = r_nq[DIV_STAGES-1];
    assign o_side  = r_ds[DIV_STAGES-1];

endmodule

`default_nettype wire
